// ===== hdl/sd_spi_init_and_partial_read_assert.svh =====
// assertion macros for the sd spi sequencer
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SD_SPI_INIT_AND_PARTIAL_READ_ASSERT_SVH
`define SD_SPI_INIT_AND_PARTIAL_READ_ASSERT_SVH

// same-cycle implication, idle while in reset
`define SDSPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle while in reset
`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sdspi_pkg.sv =====
// shared types, constants and helpers of the sd spi sequencer
// used by sdspi_step and sd_spi_init_and_partial_read; no dependencies
package sdspi_pkg;

  // sequence lengths in card bytes
  localparam logic [9:0] POWER_CLOCKS   = 10'd10;
  localparam logic [9:0] RELEASE_CLOCKS = 10'd10;
  localparam logic [9:0] CMD_LEN        = 10'd8;
  localparam logic [9:0] CRC_LEN        = 10'd2;
  localparam logic [9:0] SECTOR_BYTES   = 10'd512;
  localparam int unsigned SECTOR_SHIFT  = 9;

  // byte values on the wire
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
  localparam logic [7:0] BYTE_CMDPFX = 8'h40;
  localparam logic [7:0] BYTE_CRC    = 8'h95;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_READ_SNGL = 6'd17;

  // configuration
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RETRY    = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET_VALUE   = 16'hFFFE;

  // output queue depth
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;

  typedef enum logic [1:0] {
    FUNC_INIT = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_BYTE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_XFER = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NODISK = 2'd1,
    ST_NOINIT = 2'd2,
    ST_ERROR  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POWER     = 4'd1,
    PH_CMD       = 4'd2,
    PH_WAIT_R1   = 4'd3,
    PH_INIT_POLL = 4'd4,
    PH_TOKEN     = 4'd5,
    PH_DATA      = 4'd6,
    PH_CRC       = 4'd7,
    PH_RELEASE   = 4'd8
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [9:0]  byte_index;
    logic [15:0] poll_counter;
    logic [31:0] block_address;
    logic [8:0]  window_start;
    logic [9:0]  window_length;
    logic [5:0]  command_code;
    status_e     pending_status;
  } state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    logic       select_active;
    logic [7:0] data_byte;
    status_e    status;
    logic       last;
  } res_t;

  // transfer request result
  function automatic res_t mk_xfer(logic [7:0] tx, logic sel);
    res_t r;
    r               = '0;
    r.kind          = KIND_XFER;
    r.tx_byte       = tx;
    r.select_active = sel;
    r.last          = 1'b1;
    return r;
  endfunction

  // delivered sector byte, never the last result of its item
  function automatic res_t mk_data(logic [7:0] d);
    res_t r;
    r           = '0;
    r.kind      = KIND_DATA;
    r.data_byte = d;
    return r;
  endfunction

  // end of operation
  function automatic res_t mk_done(status_e st);
    res_t r;
    r        = '0;
    r.kind   = KIND_DONE;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // command frame byte at position idx
  function automatic logic [7:0] cmd_byte(logic [2:0] idx, logic [5:0] code,
                                          logic [31:0] addr);
    logic [7:0] b;
    unique case (idx)
      3'd1:    b = BYTE_CMDPFX | {2'b00, code};
      3'd2:    b = addr[31:24];
      3'd3:    b = addr[23:16];
      3'd4:    b = addr[15:8];
      3'd5:    b = addr[7:0];
      3'd6:    b = BYTE_CRC;
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/sd_spi_init_and_partial_read.sv =====
// Sd card host sequencer in spi mode: card init and partial read of one 512-byte block.
// Every input item is handled in the cycle it is accepted: the step logic updates the
// sequencer registers and writes its one or two results into a four-entry output queue,
// which drains one result per cycle while the consumer is ready. An item is taken whenever
// at least two queue slots are free, so with a consumer that is always ready one item enters
// every cycle; while a block is clocked in, items inside the delivery window give two results
// each and are taken only as the single output port of the queue frees slots.
// Depends on sdspi_pkg, sdspi_step and sd_spi_init_and_partial_read_assert.svh.
`include "sd_spi_init_and_partial_read_assert.svh"

module sd_spi_init_and_partial_read
  import sdspi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // sector, offset, byte_count, rx_byte, zero pad
  input  logic [1:0]           s_axis_tuser,  // func
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // tx_byte, select_active, data_byte, status, pad
  output logic [1:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast   // last
);

  state_t               state_q, state_d;
  logic [15:0]          token_timeout_q;
  logic [15:0]          init_retry_limit_q;
  res_t                 res0, res1;
  logic [1:0]           res_count;
  logic                 s_accept;
  logic                 m_accept;
  res_t                 oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0]     wptr_q, rptr_q;
  logic [OQ_AW:0]       cnt_q, cnt_d;
  logic [1:0]           push_n;
  res_t                 head;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_timeout_q    <= CFG_RESET_VALUE;
      init_retry_limit_q <= CFG_RESET_VALUE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOKEN_TIMEOUT: token_timeout_q    <= cfg_data_i;
        CFG_INIT_RETRY:    init_retry_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step logic
  sdspi_step u_step (
    .func_i             (func_e'(s_axis_tuser)),
    .sector_i           (s_axis_tdata[31:0]),
    .offset_i           (s_axis_tdata[40:32]),
    .byte_count_i       (s_axis_tdata[50:41]),
    .rx_byte_i          (s_axis_tdata[58:51]),
    .state_i            (state_q),
    .token_timeout_i    (token_timeout_q),
    .init_retry_limit_i (init_retry_limit_q),
    .state_o            (state_d),
    .res0_o             (res0),
    .res1_o             (res1),
    .res_count_o        (res_count)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, pending_status: ST_OK, default: '0};
    end else if (s_accept) begin
      state_q <= state_d;
    end
  end

  // output queue control
  assign push_n        = s_accept ? res_count : 2'd0;
  assign cnt_d         = cnt_q + {1'b0, push_n} - {{OQ_AW{1'b0}}, m_accept};
  assign s_axis_tready = cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_n[OQ_AW-1:0];
      rptr_q <= rptr_q + {{(OQ_AW-1){1'b0}}, m_accept};
      cnt_q  <= cnt_d;
    end
  end

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) oq_q[wptr_q] <= res0;
    if (push_n == 2'd2) oq_q[wptr_q + {{(OQ_AW-1){1'b0}}, 1'b1}] <= res1;
  end

  // result port
  assign head          = oq_q[rptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {5'b00000, head.status, head.data_byte, head.select_active,
                          head.tx_byte};

  // checks
  `SDSPI_ASSERT_NOW(a_oq_bound, 1'b1, cnt_q <= (OQ_AW+1)'(OQ_DEPTH), "output queue overfilled")
  `SDSPI_ASSERT_NOW(a_accept_room, s_accept, cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2), "item taken without room for its results")
  `SDSPI_ASSERT_NOW(a_idle_index, state_q.phase == PH_IDLE, state_q.byte_index == '0, "byte index left set in idle")
  `SDSPI_ASSERT_NOW(a_data_index, state_q.phase == PH_DATA, state_q.byte_index < SECTOR_BYTES, "data index past block end")
  `SDSPI_ASSERT_NEXT(a_no_phantom, !s_accept, cnt_q <= $past(cnt_q), "queue grew without an accepted item")

endmodule

// ===== hdl/sdspi_step.sv =====
// one sequencer step: next state and up to two results for one accepted item
// depends on sdspi_pkg
module sdspi_step
  import sdspi_pkg::*;
(
  input  func_e       func_i,
  input  logic [31:0] sector_i,
  input  logic [8:0]  offset_i,
  input  logic [9:0]  byte_count_i,
  input  logic [7:0]  rx_byte_i,
  input  state_t      state_i,
  input  logic [15:0] token_timeout_i,
  input  logic [15:0] init_retry_limit_i,
  output state_t      state_o,
  output res_t        res0_o,
  output res_t        res1_o,
  output logic [1:0]  res_count_o
);

  logic [9:0]  idx_inc;
  logic [15:0] poll_inc;
  logic [15:0] eff_timeout;
  logic        is_idle;
  logic        active;
  logic        power_more;
  logic        cmd_more;
  logic        crc_more;
  logic        rel_more;
  logic        in_window;
  logic        poll_expired;
  logic [10:0] window_end;

  // shared decode
  assign idx_inc      = state_i.byte_index + 10'd1;
  assign poll_inc     = state_i.poll_counter + 16'd1;
  assign eff_timeout  = (token_timeout_i == 16'd0) ? 16'd1 : token_timeout_i;
  assign poll_expired = poll_inc >= eff_timeout;
  assign is_idle      = state_i.phase == PH_IDLE;
  assign active       = ((func_i == FUNC_INIT || func_i == FUNC_READ) && is_idle) ||
                        (func_i == FUNC_BYTE && !is_idle);
  assign power_more   = idx_inc < POWER_CLOCKS;
  assign cmd_more     = idx_inc < CMD_LEN;
  assign crc_more     = idx_inc < CRC_LEN;
  assign rel_more     = idx_inc < RELEASE_CLOCKS;
  assign window_end   = {2'b00, state_i.window_start} + {1'b0, state_i.window_length};
  assign in_window    = (state_i.byte_index >= {1'b0, state_i.window_start}) &&
                        ({1'b0, state_i.byte_index} < window_end);

  // start a command frame
  function automatic state_t go_cmd(state_t s, logic [5:0] code);
    state_t n;
    n              = s;
    n.phase        = PH_CMD;
    n.byte_index   = '0;
    n.command_code = code;
    return n;
  endfunction

  // start the release clocks
  function automatic state_t go_release(state_t s, status_e st);
    state_t n;
    n                = s;
    n.phase          = PH_RELEASE;
    n.byte_index     = '0;
    n.pending_status = st;
    return n;
  endfunction

  // next state
  always_comb begin
    state_o = state_i;
    unique case (func_i)
      FUNC_INIT: begin
        if (is_idle) begin
          state_o.block_address = '0;
          state_o.phase         = PH_POWER;
          state_o.byte_index    = '0;
        end
      end
      FUNC_READ: begin
        if (is_idle) begin
          state_o.block_address = {sector_i[31-SECTOR_SHIFT:0], {SECTOR_SHIFT{1'b0}}};
          state_o.window_start  = offset_i;
          state_o.window_length = byte_count_i;
          state_o               = go_cmd(state_o, CMD_READ_SNGL);
        end
      end
      FUNC_BYTE: begin
        unique case (state_i.phase)
          PH_POWER: begin
            state_o.byte_index = idx_inc;
            if (!power_more) state_o = go_cmd(state_i, CMD_GO_IDLE);
          end
          PH_CMD: begin
            state_o.byte_index = idx_inc;
            if (!cmd_more) begin
              priority if (state_i.command_code == CMD_GO_IDLE) begin
                state_o.phase        = PH_WAIT_R1;
                state_o.poll_counter = '0;
              end else if (state_i.command_code == CMD_SEND_OP) begin
                state_o.phase = PH_INIT_POLL;
              end else begin
                state_o.phase        = PH_TOKEN;
                state_o.poll_counter = '0;
              end
            end
          end
          PH_WAIT_R1: begin
            if (rx_byte_i != BYTE_IDLE) begin
              if (rx_byte_i != R1_IDLE) begin
                state_o = go_release(state_i, ST_NODISK);
              end else begin
                state_o.phase        = PH_INIT_POLL;
                state_o.poll_counter = '0;
              end
            end else begin
              state_o.poll_counter = poll_inc;
              if (poll_expired) state_o = go_release(state_o, ST_NODISK);
            end
          end
          PH_INIT_POLL: begin
            priority if (rx_byte_i == R1_READY) begin
              state_o = go_release(state_i, ST_OK);
            end else if (state_i.poll_counter >= init_retry_limit_i) begin
              state_o = go_release(state_i, ST_NOINIT);
            end else begin
              state_o.poll_counter = poll_inc;
              state_o              = go_cmd(state_o, CMD_SEND_OP);
            end
          end
          PH_TOKEN: begin
            if (rx_byte_i == BYTE_TOKEN) begin
              state_o.phase      = PH_DATA;
              state_o.byte_index = '0;
            end else begin
              state_o.poll_counter = poll_inc;
              if (poll_expired) state_o = go_release(state_o, ST_ERROR);
            end
          end
          PH_DATA: begin
            state_o.byte_index = idx_inc;
            if (idx_inc >= SECTOR_BYTES) begin
              state_o.phase      = PH_CRC;
              state_o.byte_index = '0;
            end
          end
          PH_CRC: begin
            state_o.byte_index = idx_inc;
            if (!crc_more) state_o = go_release(state_i, ST_OK);
          end
          PH_RELEASE: begin
            state_o.byte_index = idx_inc;
            if (!rel_more) begin
              state_o.phase      = PH_IDLE;
              state_o.byte_index = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // results
  always_comb begin
    res0_o      = '0;
    res1_o      = '0;
    res_count_o = 2'd0;
    if (active) begin
      res_count_o = 2'd1;
      priority if (func_i == FUNC_INIT) begin
        res0_o = mk_xfer(BYTE_IDLE, 1'b0);
      end else if (func_i == FUNC_READ) begin
        res0_o = mk_xfer(BYTE_IDLE, 1'b1);
      end else if (state_i.phase == PH_RELEASE && !rel_more) begin
        res0_o = mk_done(state_i.pending_status);
      end else if (state_i.phase == PH_POWER && power_more) begin
        res0_o = mk_xfer(BYTE_IDLE, 1'b0);
      end else if (state_i.phase == PH_CMD && cmd_more) begin
        res0_o = mk_xfer(cmd_byte(idx_inc[2:0], state_i.command_code,
                                  state_i.block_address), 1'b1);
      end else if (state_i.phase == PH_DATA && in_window) begin
        res0_o      = mk_data(rx_byte_i);
        res1_o      = mk_xfer(BYTE_IDLE, 1'b1);
        res_count_o = 2'd2;
      end else begin
        res0_o = mk_xfer(BYTE_IDLE, 1'b1);
      end
    end
  end

endmodule
